// File: hdl/nvm_pkg.sv
// Shared types and constants for the nearest vector match block.
// Used by nvm_dist, nearest_vector_match and the testbench; depends on nothing.
`timescale 1ns / 1ps

package nvm_pkg;

    localparam int DIST_W = 41;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 41'd268435456;

    // Magnitudes above this square past the distance range.
    localparam int MAG_W = 21;
    localparam logic [63:0] MAG_LIMIT = 64'h1F_FFFF;

    localparam int TAG_W = 16;
    localparam int BEST_W = 8;
    localparam int ENTRIES_W = 9;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // Tag that travels with one element read through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic             last_dim;
        logic             last_entry;
        logic [TAG_W-1:0] entry;
    } dist_tag_t;

    // One finished entry distance.
    typedef struct packed {
        logic              valid;
        logic              last_entry;
        logic [TAG_W-1:0]  entry;
        logic [DIST_W-1:0] distance;
    } dist_res_t;

endpackage

// File: hdl/nvm_store.sv
// Reference table and query vector memories with registered reads.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module nvm_store #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int REF_DEPTH = 32768,
    parameter int QRY_DEPTH = 128,
    parameter int REF_AW = 15,
    parameter int QRY_AW = 7
) (
    input  logic                     clk,
    input  logic                     ref_we,
    input  logic [REF_AW-1:0]        ref_waddr,
    input  logic                     qry_we,
    input  logic [QRY_AW-1:0]        qry_waddr,
    input  logic [ELEMENT_WIDTH-1:0] wdata,
    input  logic                     rd_en,
    input  logic [REF_AW-1:0]        ref_raddr,
    input  logic [QRY_AW-1:0]        qry_raddr,
    output logic [ELEMENT_WIDTH-1:0] ref_rdata,
    output logic [ELEMENT_WIDTH-1:0] qry_rdata
);

    logic [ELEMENT_WIDTH-1:0] ref_mem [REF_DEPTH];
    logic [ELEMENT_WIDTH-1:0] qry_mem [QRY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= wdata;
        end
        if (rd_en)
        begin
            ref_rdata <= ref_mem[ref_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_we)
        begin
            qry_mem[qry_waddr] <= wdata;
        end
        if (rd_en)
        begin
            qry_rdata <= qry_mem[qry_raddr];
        end
    end

endmodule

// File: hdl/nvm_dist.sv
// Squared distance pipeline: difference, square, saturating accumulate.
// Depends on nvm_pkg; fed by the registered reads of nvm_store.
`timescale 1ns / 1ps

module nvm_dist #(
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nvm_pkg::dist_tag_t       req,
    input  logic [ELEMENT_WIDTH-1:0] ref_rdata,
    input  logic [ELEMENT_WIDTH-1:0] qry_rdata,
    output nvm_pkg::dist_res_t       res
);

    localparam int DW = ELEMENT_WIDTH + 1;

    nvm_pkg::dist_tag_t tag_s1_reg, tag_s2_reg, tag_s3_reg;

    logic [DW-1:0]                diff;
    logic [DW-1:0]                mag;
    logic [63:0]                  mag_wide;
    logic [nvm_pkg::MAG_W-1:0]    mag_s2_reg;
    logic                         sat_s2_reg;
    logic [2*nvm_pkg::MAG_W-1:0]  square;
    logic [nvm_pkg::DIST_W-1:0]   sq_s3_reg;
    logic [nvm_pkg::DIST_W:0]     sum;
    logic [nvm_pkg::DIST_W-1:0]   sum_sat;
    logic [nvm_pkg::DIST_W-1:0]   acc_reg;

    assign diff = DW'($signed({qry_rdata[ELEMENT_WIDTH-1], qry_rdata})
                    - $signed({ref_rdata[ELEMENT_WIDTH-1], ref_rdata}));
    assign mag = diff[DW-1] ? (~diff + 1'b1) : diff;
    assign mag_wide = 64'(mag);
    assign square = mag_s2_reg * mag_s2_reg;
    assign sum = {1'b0, acc_reg} + {1'b0, sq_s3_reg};
    assign sum_sat = sum[nvm_pkg::DIST_W] ? nvm_pkg::DIST_MAX : sum[nvm_pkg::DIST_W-1:0];

    // Control: tags, accumulator state and the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            acc_reg <= '0;
            res <= '0;
        end
        else
        begin
            tag_s1_reg <= req;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
            res.valid <= tag_s3_reg.valid && tag_s3_reg.last_dim;
            res.distance <= sum_sat;
            res.entry <= tag_s3_reg.entry;
            res.last_entry <= tag_s3_reg.last_entry;
            if (tag_s3_reg.valid)
            begin
                // restart the sum after the last dimension of each entry
                acc_reg <= tag_s3_reg.last_dim ? '0 : sum_sat;
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        mag_s2_reg <= mag_wide[nvm_pkg::MAG_W-1:0];
        sat_s2_reg <= mag_wide > nvm_pkg::MAG_LIMIT;
        if (sat_s2_reg || square > {1'b0, nvm_pkg::DIST_MAX})
        begin
            sq_s3_reg <= nvm_pkg::DIST_MAX;
        end
        else
        begin
            sq_s3_reg <= square[nvm_pkg::DIST_W-1:0];
        end
    end

endmodule

// File: hdl/nearest_vector_match.sv
// Top level of the nearest vector match block: control, search sequencer,
// running minimum and output register. Depends on nvm_pkg, nvm_store, nvm_dist.
`timescale 1ns / 1ps

// Usage
//   s_axis: one element per beat. tuser = action (0 table write, 1 query
//   element), tlast = query_last. Writes and non-last query elements are
//   taken back to back.
//   A query beat with tlast starts a search over entries 0..count-1, count
//   being entries_in_use saturated to MAX_ENTRIES. The search reads the
//   table and query memories one element per cycle, a rate set by the
//   table memory read port and the single squaring unit; s_axis_tready
//   stays low until the search result is loaded into the output register.
//   m_axis: one result beat per search, registered once the search ends.
//   The output register holds the result while m_axis_tready is low; new
//   table writes and query elements are still taken meanwhile, and a
//   following search waits at its end until the register is free.
//   cfg: always ready; index 0 entries_in_use, index 1 threshold_squared.
//   Write it only while no search runs or result is pending.
//   Reset: registers return to entries_in_use 0, threshold 1.0 squared;
//   table and query memories hold no defined contents until written.

module nearest_vector_match #(
    parameter int MAX_ENTRIES = 256,
    parameter int DIMENSIONS = 128,
    parameter int ELEMENT_WIDTH = 16,
    localparam int IN_DATA_W = ((15 + ELEMENT_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = 56
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_axis_tdata, from bit 0: entry_index[8], element_index[7],
    // element_value[ELEMENT_WIDTH], zero fill
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_DATA_W-1:0]            s_axis_tdata,
    input  logic                            s_axis_tuser,   // action
    input  logic                            s_axis_tlast,   // query_last
    // m_axis_tdata, from bit 0: best_index[8], best_distance_squared[41], zero fill
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                            m_axis_tuser,   // match_found
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nvm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nvm_pkg::DIST_W-1:0]      cfg_data
);

    localparam int REF_DEPTH = MAX_ENTRIES * DIMENSIONS;
    localparam int REF_AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int QRY_AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int ENT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [CNT_W-1:0]                entries_reg;
    logic [nvm_pkg::DIST_W-1:0]      thr_reg;
    logic [nvm_pkg::ENTRIES_W-1:0]   entries_in_use_reg;

    logic [REF_AW-1:0]               raddr_reg;
    logic [QRY_AW-1:0]               dim_reg;
    logic [ENT_W-1:0]                entry_reg;
    logic                            last_dim;
    logic                            last_entry;

    logic [nvm_pkg::DIST_W-1:0]      min_reg;
    logic [nvm_pkg::BEST_W-1:0]      best_reg;
    logic                            found_reg;

    logic                            out_valid_reg;
    logic                            out_found_reg;
    logic [nvm_pkg::BEST_W-1:0]      out_best_reg;
    logic [nvm_pkg::DIST_W-1:0]      out_dist_reg;

    logic                            in_accept;
    logic                            out_load;
    logic                            start;
    logic [7:0]                      in_entry;
    logic [6:0]                      in_elem;
    logic [ELEMENT_WIDTH-1:0]        in_value;
    logic                            elem_ok;
    logic                            entry_ok;
    logic [31:0]                     wr_lin;
    logic [CNT_W-1:0]                count;

    nvm_pkg::dist_tag_t              req;
    nvm_pkg::dist_res_t              dist_res;
    logic [ELEMENT_WIDTH-1:0]        ref_rdata;
    logic [ELEMENT_WIDTH-1:0]        qry_rdata;

    // Unpack the input beat.
    assign in_entry = s_axis_tdata[7:0];
    assign in_elem  = s_axis_tdata[14:8];
    assign in_value = s_axis_tdata[15 +: ELEMENT_WIDTH];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign elem_ok  = 32'(in_elem) < DIMENSIONS;
    assign entry_ok = 32'(in_entry) < MAX_ENTRIES;
    assign wr_lin   = 32'(in_entry) * DIMENSIONS + 32'(in_elem);
    assign start    = in_accept && (s_axis_tuser == nvm_pkg::ACTION_QUERY) && s_axis_tlast;

    // Saturate the entry count at the table size.
    assign count = (32'(entries_in_use_reg) > MAX_ENTRIES)
                 ? CNT_W'(MAX_ENTRIES) : CNT_W'(entries_in_use_reg);
    assign entries_reg = count;

    assign last_dim   = (32'(dim_reg) == DIMENSIONS - 1);
    assign last_entry = (CNT_W'(entry_reg) == entries_reg - CNT_W'(1));

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_axis_tready);

    // Issue one element read per cycle while running.
    always_comb
    begin
        req.valid = (state_reg == ST_RUN);
        req.last_dim = last_dim;
        req.last_entry = last_entry;
        req.entry = nvm_pkg::TAG_W'(entry_reg);
    end

    nvm_store #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH),
        .REF_DEPTH(REF_DEPTH),
        .QRY_DEPTH(DIMENSIONS),
        .REF_AW(REF_AW),
        .QRY_AW(QRY_AW)
    ) u_store (
        .clk(clk),
        .ref_we(in_accept && (s_axis_tuser == nvm_pkg::ACTION_WRITE) && elem_ok && entry_ok),
        .ref_waddr(wr_lin[REF_AW-1:0]),
        .qry_we(in_accept && (s_axis_tuser == nvm_pkg::ACTION_QUERY) && elem_ok),
        .qry_waddr(QRY_AW'(in_elem)),
        .wdata(in_value),
        .rd_en(req.valid),
        .ref_raddr(raddr_reg),
        .qry_raddr(dim_reg),
        .ref_rdata(ref_rdata),
        .qry_rdata(qry_rdata)
    );

    nvm_dist #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_dist (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .ref_rdata(ref_rdata),
        .qry_rdata(qry_rdata),
        .res(dist_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // no entries in use: answer a miss at once
                    state_next = (count == '0) ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_dim && last_entry)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (dist_res.valid && dist_res.last_entry)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            entries_in_use_reg <= '0;
            thr_reg <= nvm_pkg::THRESHOLD_RESET;
            raddr_reg <= '0;
            dim_reg <= '0;
            entry_reg <= '0;
            min_reg <= '0;
            best_reg <= '0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nvm_pkg::REG_ENTRIES_IN_USE)
                begin
                    entries_in_use_reg <= cfg_data[nvm_pkg::ENTRIES_W-1:0];
                end
                else if (cfg_index == nvm_pkg::REG_THRESHOLD)
                begin
                    thr_reg <= cfg_data;
                end
            end

            // Advance the read address, dimension and entry counters.
            if (start)
            begin
                raddr_reg <= '0;
                dim_reg <= '0;
                entry_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                raddr_reg <= raddr_reg + REF_AW'(1);
                if (last_dim)
                begin
                    dim_reg <= '0;
                    entry_reg <= entry_reg + ENT_W'(1);
                end
                else
                begin
                    dim_reg <= dim_reg + QRY_AW'(1);
                end
            end

            // Keep the lowest entry strictly below the running minimum.
            if (start)
            begin
                min_reg <= thr_reg;
                best_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (dist_res.valid && (dist_res.distance < min_reg))
            begin
                min_reg <= dist_res.distance;
                best_reg <= nvm_pkg::BEST_W'(dist_res.entry);
                found_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_best_reg <= best_reg;
            out_dist_reg <= min_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - nvm_pkg::BEST_W - nvm_pkg::DIST_W){1'b0}},
                            out_dist_reg, out_best_reg};

`ifndef ASSERT_OFF
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_best_reg == '0))
        else $error("miss result carries a nonzero index");

    a_hit_below_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |-> (out_dist_reg < thr_reg))
        else $error("match distance not below threshold");

    a_dist_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        dist_res.valid |-> (state_reg == ST_RUN || state_reg == ST_WAIT))
        else $error("entry distance outside a search");

    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_HOLD))
        else $error("result loaded without a finished search");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for nearest_vector_match: drives table writes, query elements
// and register writes, predicts every search result and compares it against the result stream.
// Depends on nvm_pkg and nearest_vector_match from hdl.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_ROWS = 256;
    localparam int DIMS = 128;
    localparam int IN_W = 32;
    localparam int OUT_W = 56;

    // Rows loaded at the start; every search stays within them.
    localparam int LOAD_ROWS = 8;

    localparam logic signed [15:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [15:0] ELEM_MAX = 16'sh7FFF;

    // Cycles to let the block settle after the last result before a register write.
    localparam int SETTLE_CYCLES = 16;
    // Receiver hold-off that backs the block up once results start flowing.
    localparam int HOLD_AT = 20;
    localparam int HOLD_BACKLOG = 16;
    localparam int HOLD_CYCLES = 3000;
    // An eight-row search keeps both streams quiet, and the hold-off does too.
    localparam int QUIET_LIMIT = 20000;

    // One input beat, in field order.
    typedef struct packed {
        logic                    action;
        logic [7:0]              entry;
        logic [6:0]              elem;
        logic signed [15:0]      value;
        logic                    last;
    } beat_t;

    // One search outcome.
    typedef struct packed {
        logic                            found;
        logic [nvm_pkg::BEST_W-1:0]      index;
        logic [nvm_pkg::DIST_W-1:0]      distance;
    } match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [IN_W-1:0]                  s_axis_tdata = '0;   // entry[8], elem[7], value[16], zero fill
    logic                             s_axis_tuser = 1'b0; // action
    logic                             s_axis_tlast = 1'b0; // query_last
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                 m_axis_tdata;        // best_index[8], distance[41], zero fill
    logic                             m_axis_tuser;        // match_found
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [nvm_pkg::CFG_INDEX_W-1:0]  cfg_index = nvm_pkg::REG_ENTRIES_IN_USE;
    logic [nvm_pkg::DIST_W-1:0]       cfg_data = '0;

    nearest_vector_match dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the table, the query and the registers.
    // ------------------------------------------------------------------
    logic signed [15:0] stored_rows [MAX_ROWS][DIMS];
    logic signed [15:0] query_elems [DIMS];
    logic [nvm_pkg::ENTRIES_W-1:0] rows_in_use = '0;
    logic [nvm_pkg::DIST_W-1:0]    match_limit = nvm_pkg::THRESHOLD_RESET;

    // Table contents planned for the initial load.
    logic signed [15:0] load_rows [MAX_ROWS][DIMS];

    beat_t  pending_beats [$];
    match_t expected_matches [$];

    beat_t  offered;
    beat_t  next_beat;
    match_t got_match;
    match_t want_match;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int src_idle_left = 0;
    int sink_idle_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Squared Euclidean distance from the query to one row, saturating like the block.
    function automatic logic [nvm_pkg::DIST_W-1:0] distance_to(input int row);
        logic [63:0] sum;
        logic [63:0] sq;
        logic [63:0] mag;
        int a;
        int b;
        int diff;
        sum = '0;
        for (int k = 0; k < DIMS; k++)
        begin
            a = query_elems[k];
            b = stored_rows[row][k];
            diff = a - b;
            mag = (diff < 0) ? -diff : diff;
            if (mag > nvm_pkg::MAG_LIMIT)
                sq = 64'(nvm_pkg::DIST_MAX);
            else
            begin
                sq = mag * mag;
                if (sq > nvm_pkg::DIST_MAX)
                    sq = 64'(nvm_pkg::DIST_MAX);
            end
            sum = sum + sq;
            if (sum > nvm_pkg::DIST_MAX)
                sum = 64'(nvm_pkg::DIST_MAX);
        end
        return sum[nvm_pkg::DIST_W-1:0];
    endfunction

    // Walk the rows in use; keep the first row strictly below the running minimum.
    function automatic match_t search_table(input logic [nvm_pkg::DIST_W-1:0] limit);
        match_t m;
        int count;
        logic [nvm_pkg::DIST_W-1:0] d;
        count = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
        m.found = 1'b0;
        m.index = '0;
        m.distance = limit;
        for (int e = 0; e < count; e++)
        begin
            d = distance_to(e);
            if (d < m.distance)
            begin
                m.distance = d;
                m.index = e[nvm_pkg::BEST_W-1:0];
                m.found = 1'b1;
            end
        end
        return m;
    endfunction

    // Advance the predictor by one accepted beat.
    function automatic void apply_beat(input beat_t b);
        if (b.action == nvm_pkg::ACTION_WRITE)
            stored_rows[b.entry][b.elem] = b.value;
        else
        begin
            query_elems[b.elem] = b.value;
            if (b.last)
                expected_matches = {expected_matches, search_table(match_limit)};
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] nudge(input logic signed [15:0] base,
                                                 input int spread);
        int v;
        int offset;
        offset = $urandom_range(0, 2 * spread);
        v = base;
        v = v + offset - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] random_element();
        logic [31:0] r;
        r = $urandom;
        if (r[31:28] == 4'h0)
            return ELEM_MIN;
        if (r[31:28] == 4'h1)
            return ELEM_MAX;
        return r[15:0];
    endfunction

    task automatic queue_beat(input logic action, input int entry, input int elem,
                              input logic signed [15:0] value, input logic last);
        beat_t b;
        b.action = action;
        b.entry = entry[7:0];
        b.elem = elem[6:0];
        b.value = value;
        b.last = last;
        pending_beats = {pending_beats, b};
    endtask

    // Hold until every beat is in, every result is out, and the block has settled.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; sample ready at the falling edge, handshake on the next rise.
    task automatic write_register(input logic [nvm_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [nvm_pkg::DIST_W-1:0] value);
        logic ready_seen;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
        if (index == nvm_pkg::REG_ENTRIES_IN_USE)
            rows_in_use = value[nvm_pkg::ENTRIES_W-1:0];
        else
            match_limit = value;
    endtask

    // Pick a limit: the maximum, the reset value, random, or at, just above or a quarter above the nearest distance.
    function automatic logic [nvm_pkg::DIST_W-1:0] pick_threshold();
        logic [nvm_pkg::DIST_W-1:0] nearest;
        logic [63:0] wide;
        nearest = search_table(nvm_pkg::DIST_MAX).distance;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return nvm_pkg::DIST_MAX;
            1: return wide[nvm_pkg::DIST_W-1:0];
            2: return nearest;
            3: return nearest + nvm_pkg::DIST_W'($urandom_range(1, 3));
            4: return nearest + (nearest >> 2);
            default: return nvm_pkg::THRESHOLD_RESET;
        endcase
    endfunction

    // Mostly well-formed queries near a loaded row, plus table edits and stray elements.
    task automatic queue_traffic(input int budget);
        int pushed;
        int count;
        int pick;
        int k;
        int target;
        int spread;
        int d;
        int e;
        logic signed [15:0] v;
        pushed = 0;
        count = (rows_in_use > LOAD_ROWS) ? LOAD_ROWS : rows_in_use;
        if (count == 0)
            count = LOAD_ROWS;
        while (pushed < budget)
        begin
            pick = $urandom_range(0, 99);
            target = $urandom_range(0, count - 1);
            case ($urandom_range(0, 3))
                0: spread = 0;
                1: spread = 8;
                2: spread = 200;
                default: spread = 3000;
            endcase
            if (pick < 55)
            begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    d = $urandom_range(0, DIMS - 1);
                    queue_beat(nvm_pkg::ACTION_QUERY, $urandom_range(0, 255), d,
                               nudge(stored_rows[target][d], spread), i == k - 1);
                end
                pushed += k;
            end
            else if (pick == 55)
            begin
                // whole query rebuilt around one row
                for (d = 0; d < DIMS; d++)
                    queue_beat(nvm_pkg::ACTION_QUERY, $urandom_range(0, 255), d,
                               nudge(stored_rows[target][d], spread), d == DIMS - 1);
                pushed += DIMS;
            end
            else if (pick < 80)
            begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    e = ($urandom_range(0, 99) < 80) ? $urandom_range(0, count - 1)
                                                     : $urandom_range(0, 255);
                    d = $urandom_range(0, DIMS - 1);
                    if (e < LOAD_ROWS && $urandom_range(0, 1) == 1)
                        v = nudge(stored_rows[e][d], 500);
                    else
                        v = random_element();
                    queue_beat(nvm_pkg::ACTION_WRITE, e, d, v, 1'($urandom_range(0, 1)));
                end
                pushed += k;
            end
            else
            begin
                // stray query elements with no closing beat
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    queue_beat(nvm_pkg::ACTION_QUERY, $urandom_range(0, 255),
                               $urandom_range(0, DIMS - 1), random_element(), 1'b0);
                pushed += k;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: offer the next pending beat, hold it until taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_idle_left = 0;
        end
        else
        begin
            // the beat on the bus was taken at this edge: advance the predictor
            if (s_axis_tvalid && s_axis_tready)
                apply_beat(offered);

            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the beat until it is taken
            end
            else if (src_idle_left > 0)
            begin
                src_idle_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0 && $urandom_range(0, 99) < src_idle_pct)
            begin
                src_idle_left = $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat = pending_beats.pop_front();
                offered <= next_beat;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, next_beat.value, next_beat.elem, next_beat.entry};
                s_axis_tuser <= next_beat.action;
                s_axis_tlast <= next_beat.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here once results flow and input is backed up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (!hold_done && results_seen >= HOLD_AT &&
                 pending_beats.size() > HOLD_BACKLOG)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Result monitor: check each taken beat against the oldest expectation,
    // and drive ready with random gaps, dropping it during the hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_idle_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_match.found = m_axis_tuser;
                got_match.index = m_axis_tdata[nvm_pkg::BEST_W-1:0];
                got_match.distance = m_axis_tdata[nvm_pkg::BEST_W +: nvm_pkg::DIST_W];
                if (expected_matches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d unexpected: found=%0b idx=%0d dist=%0d",
                                 results_seen, got_match.found, got_match.index,
                                 got_match.distance);
                end
                else
                begin
                    want_match = expected_matches.pop_front();
                    if (got_match.found !== want_match.found ||
                        got_match.index !== want_match.index ||
                        got_match.distance !== want_match.distance)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected found=%0b idx=%0d dist=%0d,",
                                     results_seen, want_match.found, want_match.index,
                                     want_match.distance,
                                     " got found=%0b idx=%0d dist=%0d",
                                     got_match.found, got_match.index,
                                     got_match.distance);
                    end
                end
                results_seen++;
            end

            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_left > 0)
            begin
                sink_idle_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_idle_pct)
            begin
                sink_idle_left = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nearest_vector_match test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int e;
        int d;
        int ph;
        int rows;
        int budget;
        logic signed [15:0] v;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: a search over no rows misses and reports the reset limit.
        queue_beat(nvm_pkg::ACTION_QUERY, 0, DIMS - 1, ELEM_MIN, 1'b1);

        // Load the rows used by every later search. Row 1 copies row 0 so that
        // the two tie; rows 2..4 are all zero, all max and all min.
        src_idle_pct = 10;
        sink_idle_pct = 10;
        for (e = 0; e < LOAD_ROWS; e++)
        begin
            for (d = 0; d < DIMS; d++)
            begin
                case (e)
                    0: v = nudge(16'sd0, 2000);
                    1: v = load_rows[0][d];
                    2: v = 16'sd0;
                    3: v = ELEM_MAX;
                    4: v = ELEM_MIN;
                    default: v = (e == 5) ? random_element()
                                          : nudge(load_rows[e - 1][d], 1500);
                endcase
                load_rows[e][d] = v;
                queue_beat(nvm_pkg::ACTION_WRITE, e, d, v, 1'($urandom_range(0, 1)));
            end
        end
        // Fill the whole query close to row 0; still no rows in use, so a miss.
        for (d = 0; d < DIMS; d++)
            queue_beat(nvm_pkg::ACTION_QUERY, $urandom_range(0, 255), d,
                       nudge(load_rows[0][d], 20), d == DIMS - 1);
        wait_drained();

        // Five rows, widest limit: ties go to the lower row.
        write_register(nvm_pkg::REG_ENTRIES_IN_USE, nvm_pkg::DIST_W'(5));
        write_register(nvm_pkg::REG_THRESHOLD, nvm_pkg::DIST_MAX);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 0, query_elems[0], 1'b1);
        // push row 0 away, row 1 wins; tlast on a table write is ignored
        queue_beat(nvm_pkg::ACTION_WRITE, 0, 3, ELEM_MAX, 1'b1);
        queue_beat(nvm_pkg::ACTION_QUERY, 255, 1, query_elems[1], 1'b1);
        queue_beat(nvm_pkg::ACTION_WRITE, 0, 3, stored_rows[0][3], 1'b0);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 2, ELEM_MAX, 1'b0);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 2, query_elems[2], 1'b1);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 10, ELEM_MIN, 1'b0);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 11, ELEM_MAX, 1'b1);
        queue_beat(nvm_pkg::ACTION_WRITE, 255, DIMS - 1, ELEM_MIN, 1'b0);
        queue_beat(nvm_pkg::ACTION_QUERY, 255, DIMS - 1, 16'sd0, 1'b1);
        wait_drained();

        // Zero limit: nothing can be strictly below it.
        write_register(nvm_pkg::REG_THRESHOLD, '0);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 0, query_elems[0], 1'b1);
        wait_drained();

        // Limit equal to the nearest distance misses; one above it hits.
        write_register(nvm_pkg::REG_THRESHOLD, search_table(nvm_pkg::DIST_MAX).distance);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 0, query_elems[0], 1'b1);
        wait_drained();
        write_register(nvm_pkg::REG_THRESHOLD,
                       search_table(nvm_pkg::DIST_MAX).distance + nvm_pkg::DIST_W'(1));
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 0, query_elems[0], 1'b1);
        wait_drained();

        // No rows in use misses even with the widest limit.
        write_register(nvm_pkg::REG_ENTRIES_IN_USE, '0);
        write_register(nvm_pkg::REG_THRESHOLD, nvm_pkg::DIST_MAX);
        queue_beat(nvm_pkg::ACTION_QUERY, 0, 5, query_elems[5], 1'b1);
        wait_drained();

        // Random phases over the loaded rows, calm final phase.
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 3)
                rows = LOAD_ROWS;
            else if ($urandom_range(0, 9) == 0)
                rows = 0;
            else
                rows = $urandom_range(1, LOAD_ROWS);
            write_register(nvm_pkg::REG_ENTRIES_IN_USE, nvm_pkg::DIST_W'(rows));
            write_register(nvm_pkg::REG_THRESHOLD, pick_threshold());
            if (ph == 9)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 10;
                    default: src_idle_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_idle_pct = 0;
                    1: sink_idle_pct = 10;
                    default: sink_idle_pct = 35;
                endcase
            end
            budget = 50;
            queue_traffic(budget);
            wait_drained();
        end

        if (mismatches == 0 && expected_matches.size() == 0)
            $display("nearest_vector_match test passed");
        else
            $display("nearest_vector_match test failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/nvm_pkg.sv
hdl/nvm_store.sv
hdl/nvm_dist.sv
hdl/nearest_vector_match.sv
sim/testbench.sv
